@@ hdl/masked_route_table_lookup_macros.svh @@
// assertion macros for the route table lookup block
// expects clk_i and rst_ni in the scope of each use
`ifndef MASKED_ROUTE_TABLE_LOOKUP_MACROS_SVH
`define MASKED_ROUTE_TABLE_LOOKUP_MACROS_SVH

// same-cycle implication, held off during reset
`define MRTL_ASSERT_IMPL(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("mrtl: same-cycle check failed");

// next-cycle implication, held off during reset
`define MRTL_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("mrtl: next-cycle check failed");

`endif

@@ hdl/mrtl_pkg.sv @@
// shared types, constants and helpers of the route table lookup block
// no dependencies
`default_nettype none

package mrtl_pkg;

  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned IP_W        = 32;
  localparam int unsigned RAM_W       = 2 * IP_W;
  localparam int unsigned IDX_W       = 4;
  localparam int unsigned CFG_W       = 5;

  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  localparam logic [7:0] OCT_TEN      = 8'd10;
  localparam logic [7:0] OCT_172      = 8'd172;
  localparam logic [7:0] OCT_16       = 8'd16;
  localparam logic [7:0] OCT_31       = 8'd31;
  localparam logic [7:0] OCT_192      = 8'd192;
  localparam logic [7:0] OCT_168      = 8'd168;

  typedef enum logic [2:0] {
    ST_WRITTEN = 3'd0,
    ST_INVALID = 3'd1,
    ST_NETADDR = 3'd2,
    ST_HIT     = 3'd3,
    ST_MISS    = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    SC_IDLE,
    SC_SCAN,
    SC_EMIT
  } scan_state_e;

  typedef struct packed {
    logic            req_type;
    logic [IDX_W-1:0] entry_index;
    logic [IP_W-1:0] route_net;
    logic [IP_W-1:0] route_mask;
    logic [IP_W-1:0] query_addr;
  } in_word_t;

  typedef struct packed {
    status_e          status;
    logic             is_public;
    logic [IDX_W-1:0] hit_index;
  } out_word_t;

  // table memory port request, data packed as {mask, net}
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [RAM_W-1:0]  wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    logic              busy;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [CNT_W-1:0]  active;
  } scan_stat_t;

  function automatic logic is_private(input logic [IP_W-1:0] addr);
    logic [7:0] o0;
    logic [7:0] o1;
    o0 = addr[31:24];
    o1 = addr[23:16];
    return (o0 == OCT_TEN) ||
           ((o0 == OCT_172) && (o1 >= OCT_16) && (o1 <= OCT_31)) ||
           ((o0 == OCT_192) && (o1 == OCT_168));
  endfunction

  // entries in use, capped at the table depth
  function automatic logic [CNT_W-1:0] active_entries(input logic [CFG_W-1:0] cnt);
    if (32'(cnt) > TABLE_DEPTH) begin
      return CNT_W'(TABLE_DEPTH);
    end
    return CNT_W'(cnt);
  endfunction

endpackage

`default_nettype wire

@@ hdl/mrtl_ram.sv @@
// generic single-port-write, single-port-read ram with registered read
// no dependencies
`default_nettype none

module mrtl_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16
) (
  input  wire                                       clk_i,
  input  wire                                       we_i,
  input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire  [WIDTH-1:0]                          wdata_i,
  input  wire                                       re_i,
  input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ hdl/mrtl_scan.sv @@
// request sequencer: table writes, address checks and the table walk
// depends on mrtl_pkg
`default_nettype none

module mrtl_scan (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         in_valid_i,
  output logic                        in_ready_o,
  input  mrtl_pkg::in_word_t          in_word_i,
  input  wire  [mrtl_pkg::CFG_W-1:0]  entry_count_i,
  output mrtl_pkg::ram_req_t          ram_req_o,
  input  wire  [mrtl_pkg::RAM_W-1:0]  ram_rdata_i,
  output logic                        res_valid_o,
  input  wire                         res_ready_i,
  output mrtl_pkg::out_word_t         res_word_o,
  output mrtl_pkg::scan_stat_t        stat_o
);

  mrtl_pkg::scan_state_e state_q, state_d;

  logic                          cmp_vld_q, cmp_vld_d;
  logic [mrtl_pkg::IP_W-1:0]     addr_q, addr_d;
  logic [mrtl_pkg::CNT_W-1:0]    n_q, n_d;
  logic                          pub_q, pub_d;
  logic [mrtl_pkg::CNT_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [mrtl_pkg::ADDR_W-1:0]   cmp_idx_q, cmp_idx_d;
  logic                          net_seen_q, net_seen_d;
  logic                          hit_q, hit_d;
  logic [mrtl_pkg::ADDR_W-1:0]   hit_idx_q, hit_idx_d;
  mrtl_pkg::out_word_t           res_q, res_d;

  logic                          accept;
  logic                          is_lookup;
  logic                          addr_bad;
  logic [mrtl_pkg::CNT_W-1:0]    n_now;
  logic                          rd_issue;
  logic                          last_cmp;
  logic [mrtl_pkg::IP_W-1:0]     ent_net;
  logic [mrtl_pkg::IP_W-1:0]     ent_mask;
  logic                          net_eq;
  logic                          mask_eq;
  logic                          net_seen_nx;
  logic                          hit_nx;
  logic [mrtl_pkg::ADDR_W-1:0]   hit_idx_nx;

  assign in_ready_o = (state_q == mrtl_pkg::SC_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign is_lookup  = (in_word_i.req_type == mrtl_pkg::REQ_LOOKUP);
  assign addr_bad   = (in_word_i.query_addr == '0) || (in_word_i.query_addr == '1);
  assign n_now      = mrtl_pkg::active_entries(entry_count_i);

  assign rd_issue   = (state_q == mrtl_pkg::SC_SCAN) && (rd_ptr_q < n_q);
  assign last_cmp   = cmp_vld_q &&
                      ((mrtl_pkg::CNT_W'(cmp_idx_q) + mrtl_pkg::CNT_W'(1)) == n_q);

  assign ent_net    = ram_rdata_i[mrtl_pkg::IP_W-1:0];
  assign ent_mask   = ram_rdata_i[mrtl_pkg::RAM_W-1:mrtl_pkg::IP_W];
  assign net_eq     = (ent_net == addr_q);
  assign mask_eq    = ((addr_q & ent_mask) == (ent_net & ent_mask));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mrtl_pkg::SC_IDLE: begin
        if (accept) begin
          if (is_lookup && !addr_bad && (n_now != '0)) begin
            state_d = mrtl_pkg::SC_SCAN;
          end else begin
            state_d = mrtl_pkg::SC_EMIT;
          end
        end
      end
      mrtl_pkg::SC_SCAN: begin
        if (last_cmp) begin
          state_d = mrtl_pkg::SC_EMIT;
        end
      end
      mrtl_pkg::SC_EMIT: begin
        if (res_ready_i) begin
          state_d = mrtl_pkg::SC_IDLE;
        end
      end
      default: state_d = mrtl_pkg::SC_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ram_req_o.we    = accept && !is_lookup &&
                      (32'(in_word_i.entry_index) < mrtl_pkg::TABLE_DEPTH);
    ram_req_o.waddr = mrtl_pkg::ADDR_W'(in_word_i.entry_index);
    ram_req_o.wdata = {in_word_i.route_mask, in_word_i.route_net};
    ram_req_o.re    = rd_issue;
    ram_req_o.raddr = rd_ptr_q[mrtl_pkg::ADDR_W-1:0];
    res_valid_o     = (state_q == mrtl_pkg::SC_EMIT);
    res_word_o      = res_q;
    stat_o.busy     = (state_q != mrtl_pkg::SC_IDLE);
    stat_o.rd_en    = rd_issue;
    stat_o.rd_addr  = rd_ptr_q[mrtl_pkg::ADDR_W-1:0];
    stat_o.active   = n_q;
  end

  // walk datapath
  always_comb begin
    addr_d      = addr_q;
    n_d         = n_q;
    pub_d       = pub_q;
    rd_ptr_d    = rd_ptr_q;
    cmp_vld_d   = 1'b0;
    cmp_idx_d   = rd_ptr_q[mrtl_pkg::ADDR_W-1:0];
    net_seen_d  = net_seen_q;
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    res_d       = res_q;

    net_seen_nx = net_seen_q || net_eq;
    hit_nx      = hit_q || mask_eq;
    hit_idx_nx  = hit_q ? hit_idx_q : cmp_idx_q;

    if (accept) begin
      addr_d     = in_word_i.query_addr;
      n_d        = n_now;
      pub_d      = !mrtl_pkg::is_private(in_word_i.query_addr);
      rd_ptr_d   = '0;
      net_seen_d = 1'b0;
      hit_d      = 1'b0;
      hit_idx_d  = '0;
      if (!is_lookup) begin
        res_d = '{status: mrtl_pkg::ST_WRITTEN, is_public: 1'b0, hit_index: '0};
      end else if (addr_bad) begin
        res_d = '{status: mrtl_pkg::ST_INVALID, is_public: 1'b0, hit_index: '0};
      end else begin
        // valid lookup: miss by default, final on an empty table, else replaced by the walk
        res_d = '{status: mrtl_pkg::ST_MISS,
                  is_public: !mrtl_pkg::is_private(in_word_i.query_addr),
                  hit_index: '0};
      end
    end

    if (rd_issue) begin
      rd_ptr_d  = rd_ptr_q + mrtl_pkg::CNT_W'(1);
      cmp_vld_d = 1'b1;
    end

    if (cmp_vld_q) begin
      net_seen_d = net_seen_nx;
      hit_d      = hit_nx;
      hit_idx_d  = hit_nx ? hit_idx_nx : hit_idx_q;
      if (last_cmp) begin
        if (net_seen_nx) begin
          res_d = '{status: mrtl_pkg::ST_NETADDR, is_public: 1'b0, hit_index: '0};
        end else if (hit_nx) begin
          res_d = '{status: mrtl_pkg::ST_HIT, is_public: pub_q,
                    hit_index: mrtl_pkg::IDX_W'(hit_idx_nx)};
        end else begin
          res_d = '{status: mrtl_pkg::ST_MISS, is_public: pub_q, hit_index: '0};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= mrtl_pkg::SC_IDLE;
      cmp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cmp_vld_q <= cmp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q     <= addr_d;
    n_q        <= n_d;
    pub_q      <= pub_d;
    rd_ptr_q   <= rd_ptr_d;
    cmp_idx_q  <= cmp_idx_d;
    net_seen_q <= net_seen_d;
    hit_q      <= hit_d;
    hit_idx_q  <= hit_idx_d;
    res_q      <= res_d;
  end

endmodule

`default_nettype wire

@@ hdl/masked_route_table_lookup.sv @@
// top level of the first-match route table lookup block
// depends on mrtl_pkg, mrtl_ram, mrtl_scan and the assertion macro header
//
// channel   direction  word            handshake
// in        in         in_word_t       in_valid_i / in_ready_o
// out       out        out_word_t      out_valid_o / out_ready_i
// cfg       in         entry_count     cfg_valid_i / cfg_ready_o
//
// a table write goes from acceptance straight to the emit state, held until taken
// a lookup of an invalid address, or with no entries in use, does the same
// any other lookup first walks the n entries in use, then emits; the walk
// reads one entry per cycle through the table memory read port
// reset clears control and the entry count; the table itself holds garbage until written
// a stalled output keeps its word in the output register while the next word is worked on
`default_nettype none
`include "masked_route_table_lookup_macros.svh"

module masked_route_table_lookup (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         in_valid_i,
  output logic                        in_ready_o,
  input  mrtl_pkg::in_word_t          in_word_i,
  output logic                        out_valid_o,
  input  wire                         out_ready_i,
  output mrtl_pkg::out_word_t         out_word_o,
  input  wire                         cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire  [mrtl_pkg::CFG_W-1:0]  cfg_data_i
);

  // entry count register, always writable
  logic [mrtl_pkg::CFG_W-1:0] cnt_q;

  // table memory: {mask, net} per entry
  mrtl_pkg::ram_req_t         ram_req;
  logic [mrtl_pkg::RAM_W-1:0] ram_rdata;

  // sequencer result and status
  logic                       res_valid;
  logic                       res_ready;
  mrtl_pkg::out_word_t        res_word;
  mrtl_pkg::scan_stat_t       stat;

  // output register, parts the sequencer from the consumer
  logic                       out_vld_q;
  mrtl_pkg::out_word_t        out_word_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      cnt_q <= cfg_data_i;
    end
  end

  mrtl_ram #(
    .WIDTH (mrtl_pkg::RAM_W),
    .DEPTH (mrtl_pkg::TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

  // writes land in the memory at acceptance, so a later walk always sees them
  mrtl_scan u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_word_i     (in_word_i),
    .entry_count_i (cnt_q),
    .ram_req_o     (ram_req),
    .ram_rdata_i   (ram_rdata),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_word_o    (res_word),
    .stat_o        (stat)
  );

  // result moves on when the output register is empty or draining
  assign res_ready = !out_vld_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_ready) begin
      out_vld_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_word_q <= res_word;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_word_q;

  // the walk never reads past the entries in use
  `MRTL_ASSERT_IMPL(a_rd_in_range, stat.rd_en,
                    mrtl_pkg::CNT_W'(stat.rd_addr) < stat.active)
  // only one word in flight inside the sequencer
  `MRTL_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, stat.busy && !in_ready_o)
  // hit index is zero on anything but a hit
  `MRTL_ASSERT_IMPL(a_idx_only_on_hit,
                    out_valid_o && (out_word_o.status != mrtl_pkg::ST_HIT),
                    out_word_o.hit_index == '0)
  // class bit is zero on written, invalid and network-address words
  `MRTL_ASSERT_IMPL(a_pub_only_on_lookup,
                    out_valid_o && (out_word_o.status != mrtl_pkg::ST_HIT) &&
                    (out_word_o.status != mrtl_pkg::ST_MISS),
                    !out_word_o.is_public)

endmodule

`default_nettype wire
